### hdl/lkvt_pkg.sv
// lkvt_pkg: item formats, operation and status codes, controller states and
// the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package lkvt_pkg;

	localparam int CMD_W     = 3;
	localparam int KEY_IO_W  = 32;
	localparam int VAL_IO_W  = 32;
	localparam int IDX_W     = 6;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 7;

	// operation codes carried in the cmd field
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GET_AT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [KEY_IO_W-1:0] key_in;
		logic [VAL_IO_W-1:0] value_in;
		logic [IDX_W-1:0]    index_in;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_IO_W-1:0] key_out;
		logic [VAL_IO_W-1:0] value_out;
		logic [COUNT_W-1:0]  count;
	} rsp_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_IDX_RD,
		S_IDX_CAP,
		S_RESP
	} state_t;

	// what the result register is built from
	typedef enum logic [2:0] {
		RK_EMPTY,   // ok, zero key/value
		RK_MISS,
		RK_FULL,
		RK_RANGE,
		RK_REQ,     // ok, key/value of the request
		RK_HOLD     // ok, key/value captured from the table
	} res_kind_t;

	typedef enum logic [1:0] {
		RD_PTR,
		RD_NEXT,
		RD_IDX
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_APPEND,
		WR_UPDATE,
		WR_SHIFT
	} wr_sel_t;

	typedef struct packed {
		logic      load_req;
		logic      ptr_clr;
		logic      ptr_inc;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		wr_sel_t   wr_sel;
		logic      hold_cap;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      cnt_clr;
		logic      res_load;
		res_kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             at_end;     // scan pointer reached the count
		logic             last_move;  // no entry above the pointer
		logic             key_hit;
		logic             idx_ok;
		logic             full;
		logic             out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

### hdl/lkvt_ram.sv
// lkvt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lkvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/lkvt_ctrl.sv
// lkvt_ctrl: sequencer for the table operations (scan, shift-down, indexed read).
// Depends on lkvt_pkg.
`default_nettype none

module lkvt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire lkvt_pkg::dp_stat_t stat,
	output lkvt_pkg::dp_cmd_t       cmd
);

	import lkvt_pkg::*;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RK_EMPTY;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.rd_sel   = RD_PTR;
		cmd.wr_sel   = WR_APPEND;
		cmd.res_kind = kind_q;

		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					cmd.ptr_clr  = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op)
					CMD_FIND, CMD_INSERT, CMD_ERASE: begin
						state_d = S_SCAN_RD;
					end
					CMD_GET_AT: begin
						if (stat.idx_ok) begin
							state_d = S_IDX_RD;
						end else begin
							kind_d  = RK_RANGE;
							state_d = S_RESP;
						end
					end
					CMD_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						kind_d      = RK_EMPTY;
						state_d     = S_RESP;
					end
					default: begin
						kind_d  = RK_EMPTY;
						state_d = S_RESP;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (stat.at_end) begin
					// no match anywhere
					if (stat.op == CMD_INSERT) begin
						if (stat.full) begin
							kind_d = RK_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WR_APPEND;
							cmd.cnt_inc = 1'b1;
							kind_d      = RK_REQ;
						end
					end else begin
						kind_d = RK_MISS;
					end
					state_d = S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR;
					state_d    = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (stat.key_hit) begin
					if (stat.op == CMD_INSERT) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_UPDATE;
						kind_d     = RK_REQ;
						state_d    = S_RESP;
					end else begin
						cmd.hold_cap = 1'b1;
						kind_d       = RK_HOLD;
						state_d      = (stat.op == CMD_ERASE) ? S_SHIFT_RD : S_RESP;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				if (stat.last_move) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.ptr_inc = 1'b1;
				state_d     = S_SHIFT_RD;
			end
			S_IDX_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_IDX_CAP;
			end
			S_IDX_CAP: begin
				cmd.hold_cap = 1'b1;
				kind_d       = RK_HOLD;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// a result is loaded only when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> stat.out_free)
		else $error("result loaded while output register busy");

	// an accepted item is always dispatched next
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_DISPATCH))
		else $error("accepted item not dispatched");

	// shift-down only follows a hit on erase
	a_shift_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_RD && $past(state_q) == S_SCAN_CMP) |->
			($past(stat.key_hit) && stat.op == CMD_ERASE))
		else $error("shift-down entered without an erase hit");

endmodule

`default_nettype wire

### hdl/lkvt_dp.sv
// lkvt_dp: entry RAM, request/hold registers, count and pointer, result register.
// Depends on lkvt_pkg and lkvt_ram.
`default_nettype none

module lkvt_dp #(
	parameter int CAPACITY    = 64,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lkvt_pkg::req_item_t req,
	input  wire lkvt_pkg::dp_cmd_t   cmd,
	output lkvt_pkg::dp_stat_t       stat,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output lkvt_pkg::rsp_item_t      rsp
);

	import lkvt_pkg::*;

	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int XW  = (CW > IDX_W) ? CW : IDX_W;
	localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int EW  = KEY_WIDTH + VALUE_WIDTH;

	// request registers
	logic [CMD_W-1:0]       op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [IDX_W-1:0]       idx_q;

	// entry captured for the result
	logic [KEY_WIDTH-1:0]   hold_key_q;
	logic [VALUE_WIDTH-1:0] hold_val_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] ptr_next;

	logic          rsp_valid_q;
	rsp_item_t     rsp_q;
	rsp_item_t     res_d;

	logic [63:0]   key_in_w, val_in_w;
	logic [XW-1:0] idx_x, cnt_x;
	logic [CXW-1:0] cnt_out_x;
	logic [63:0]   key_req_w, val_req_w, key_hold_w, val_hold_w;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;

	assign key_in_w  = 64'(req.key_in);
	assign val_in_w  = 64'(req.value_in);
	assign ptr_next  = ptr_q + CW'(1);
	assign idx_x     = XW'(idx_q);
	assign cnt_x     = XW'(count_q);
	assign cnt_out_x = CXW'(count_q);
	assign rd_key    = ram_rdata[EW-1:VALUE_WIDTH];
	assign rd_val    = ram_rdata[VALUE_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= req.cmd;
			key_q <= key_in_w[KEY_WIDTH-1:0];
			val_q <= val_in_w[VALUE_WIDTH-1:0];
			idx_q <= req.index_in;
		end
		if (cmd.hold_cap) begin
			hold_key_q <= rd_key;
			hold_val_q <= rd_val;
		end
		if (cmd.res_load) begin
			rsp_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_next;
			end
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// RAM addressing
	always_comb begin
		unique case (cmd.rd_sel)
			RD_PTR:  ram_raddr = ptr_q[AW-1:0];
			RD_NEXT: ram_raddr = ptr_next[AW-1:0];
			RD_IDX:  ram_raddr = idx_x[AW-1:0];
			default: ram_raddr = ptr_q[AW-1:0];
		endcase
		ram_we = cmd.wr_en;
		unique case (cmd.wr_sel)
			WR_APPEND: begin
				ram_waddr = count_q[AW-1:0];
				ram_wdata = {key_q, val_q};
			end
			WR_UPDATE: begin
				ram_waddr = ptr_q[AW-1:0];
				ram_wdata = {key_q, val_q};
			end
			WR_SHIFT: begin
				ram_waddr = ptr_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_waddr = ptr_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
		endcase
	end

	lkvt_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result assembly
	assign key_req_w  = 64'(key_q);
	assign val_req_w  = 64'(val_q);
	assign key_hold_w = 64'(hold_key_q);
	assign val_hold_w = 64'(hold_val_q);

	always_comb begin
		res_d.status    = STATUS_OK;
		res_d.key_out   = '0;
		res_d.value_out = '0;
		res_d.count     = cnt_out_x[COUNT_W-1:0];
		unique case (cmd.res_kind)
			RK_EMPTY: res_d.status = STATUS_OK;
			RK_MISS:  res_d.status = STATUS_NOT_FOUND;
			RK_FULL:  res_d.status = STATUS_FULL;
			RK_RANGE: res_d.status = STATUS_RANGE;
			RK_REQ: begin
				res_d.key_out   = key_req_w[KEY_IO_W-1:0];
				res_d.value_out = val_req_w[VAL_IO_W-1:0];
			end
			RK_HOLD: begin
				res_d.key_out   = key_hold_w[KEY_IO_W-1:0];
				res_d.value_out = val_hold_w[VAL_IO_W-1:0];
			end
			default: res_d.status = STATUS_OK;
		endcase
	end

	assign stat.op        = op_q;
	assign stat.at_end    = (ptr_q >= count_q);
	assign stat.last_move = (ptr_next >= count_q);
	assign stat.key_hit   = (rd_key == key_q);
	assign stat.idx_ok    = (idx_x < cnt_x);
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// append never happens on a full table
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !stat.full)
		else $error("append on full table");

	// a shift writes only below the last live entry
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_sel == WR_SHIFT) |-> (ptr_next < count_q))
		else $error("shift write beyond live entries");

	// count moves by at most one entry per cycle except on clear
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.cnt_clr) |->
			(count_q == $past(count_q) ||
			 count_q == $past(count_q) + CW'(1) ||
			 count_q == $past(count_q) - CW'(1)))
		else $error("entry count jumped");

endmodule

`default_nettype wire

### hdl/linear_key_value_table.sv
// linear_key_value_table: top level of the linear-search key/value table.
// Depends on lkvt_pkg, lkvt_ctrl, lkvt_dp (which holds lkvt_ram).
//
// A compacted table of up to CAPACITY key/value pairs kept in insertion
// order. Each request item (cmd, key_in, value_in, index_in) yields exactly
// one response item (status, key_out, value_out, count), in order. find
// returns the first matching entry; insert updates a present key or appends,
// answering full at capacity; erase removes the first match and moves every
// later entry down one slot; get_at reads the entry at index_in when it is
// below the count; clear empties the table; unused cmd codes change nothing
// and answer ok with zero key and value. One item is in work at a time.
// After acceptance an item passes a dispatch state, then the linear scan
// visits the entries in order (the entry RAM has a registered read, so
// each entry is a read step followed by a compare step); a scan that runs
// past the last entry adds a closing step, an erase then moves every later
// entry down one at a time (read slot i+1, write slot i) and adds a closing
// step, and a final step loads the output register once it is free. get_at
// reads the entry in a read step and a capture step; get_at out of range,
// clear and unused codes go from dispatch straight to the final step. The
// next item is taken in the cycle after the previous result is loaded into
// the output register, even while that result still waits for rsp_ready.
// The entry RAM is not cleared at reset; the count is, and entries at or
// above the count are never read.
`default_nettype none

module linear_key_value_table #(
	parameter int CAPACITY    = 64,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire lkvt_pkg::req_item_t req,
	// response channel
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output lkvt_pkg::rsp_item_t      rsp
);

	import lkvt_pkg::*;

	// controller <-> datapath bundles
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// sequencer: decides per cycle what the datapath does
	lkvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// storage, count, scan pointer and the output register
	lkvt_dp #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
